@@ rtl/first_fit_piece_allocator_top_macros.svh @@
// assertion macros for the first-fit piece allocator
`ifndef FIRST_FIT_PIECE_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_PIECE_ALLOCATOR_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define FFPA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define FFPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ffpa_pkg.sv @@
// shared types and constants of the first-fit piece allocator
package ffpa_pkg;

    localparam int OFS_W   = 14;
    localparam int SIZE_W  = 19;
    localparam int BYTES_W = 18;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_BAD   = 2'd3
    } req_t;

    // classified word passed from front to back
    typedef struct packed {
        req_t             kind;
        logic [OFS_W:0]   need;
        logic [OFS_W-1:0] hdr;
        logic             ofs_ok;
    } cmd_t;

endpackage

@@ rtl/ffpa_front.sv @@
// front part: accepts words, classifies them and fills the command queue
module ffpa_front
    import ffpa_pkg::*;
#(
    parameter int PIECES = 16384,
    parameter int DEPTH  = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [SIZE_W-1:0] size_bytes,
    input  logic [OFS_W-1:0]  data_offset,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_take
);

    localparam int AW = $clog2(DEPTH);

    cmd_t            q_reg [DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   rd_reg;
    logic [AW:0]     cnt_reg;
    cmd_t            c;
    logic [OFS_W-1:0] hdr;
    logic [SIZE_W:0] size_up;
    logic            push;
    logic            pop;

    // piece count saturates, anything that large can never fit
    always_comb
    begin
        hdr = data_offset - OFS_W'(1);
        size_up = {1'b0, size_bytes} + (SIZE_W+1)'(15);
        c.kind = req_t'(req_type);
        c.need = size_up[SIZE_W] ? '1 : size_up[SIZE_W-1:4];
        c.hdr = hdr;
        c.ofs_ok = (data_offset != '0) && ({1'b0, hdr} < (OFS_W+1)'(PIECES));
    end

    assign in_stall  = (cnt_reg == (AW+1)'(DEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_take && cmd_valid;
    assign cmd       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= AW'((32'(wr_reg) + 1) % DEPTH);
            end
            if (pop)
            begin
                rd_reg <= AW'((32'(rd_reg) + 1) % DEPTH);
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

@@ rtl/ffpa_back.sv @@
// back part: walks the chunk list in header memory and produces results
module ffpa_back
    import ffpa_pkg::*;
#(
    parameter int PIECES = 16384
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_take,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [OFS_W-1:0]   granted_offset,
    output logic [BYTES_W-1:0] chunk_bytes,
    output logic               busy
);

    // header word: next, pieces, free
    localparam int HW = 2 * OFS_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_WAIT, S_EVAL, S_SPLIT, S_OUT
    } state_t;

    logic [HW-1:0]      mem [PIECES];
    logic [HW-1:0]      rdata_reg;
    logic [OFS_W-1:0]   raddr;
    logic               we;
    logic [OFS_W-1:0]   waddr;
    logic [HW-1:0]      wdata;

    state_t             state_reg, state_next;
    cmd_t               c_reg, c_next;
    logic [OFS_W-1:0]   h_reg, h_next;
    logic [OFS_W:0]     steps_reg, steps_next;
    logic               ov_reg, ov_next;
    logic               st_reg, st_next;
    logic [OFS_W-1:0]   go_reg, go_next;
    logic [BYTES_W-1:0] cb_reg, cb_next;
    logic               h0_reg, h0_next;

    logic [OFS_W-1:0]   nx;
    logic [OFS_W-1:0]   pc;
    logic               fr;
    logic [OFS_W+1:0]   rest;

    // entry 0 not yet written reads as the reset header
    always_comb
    begin
        if (h0_reg && h_reg == '0)
        begin
            nx = '0;
            pc = OFS_W'(PIECES - 1);
            fr = 1'b1;
        end
        else
        begin
            {nx, pc, fr} = rdata_reg;
        end
        rest = (OFS_W+2)'(h_reg) + (OFS_W+2)'(c_reg.need) + (OFS_W+2)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        h_next     = h_reg;
        steps_next = steps_reg;
        ov_next    = ov_reg;
        st_next    = st_reg;
        go_next    = go_reg;
        cb_next    = cb_reg;
        h0_next    = h0_reg;
        cmd_take   = 1'b0;
        we         = 1'b0;
        waddr      = h_reg;
        wdata      = {nx, pc, fr};
        raddr      = h_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    c_next     = cmd;
                    steps_next = '0;
                    st_next    = 1'b1;
                    go_next    = '0;
                    cb_next    = '0;
                    h_next     = (cmd.kind == REQ_ALLOC) ? '0 : cmd.hdr;
                    if (cmd.kind == REQ_BAD || !cmd.ofs_ok && cmd.kind != REQ_ALLOC)
                    begin
                        st_next    = (cmd.kind != REQ_FREE);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_OUT;
                case (c_reg.kind)
                    REQ_FREE:
                    begin
                        we      = 1'b1;
                        wdata   = {nx, pc, 1'b1};
                        h0_next = h0_reg && (h_reg != '0);
                        st_next = 1'b0;
                    end
                    REQ_QUERY:
                    begin
                        st_next = 1'b0;
                        cb_next = {pc, 4'b0};
                    end
                    default:
                    begin
                        if (fr && {1'b0, pc} == c_reg.need)
                        begin
                            we      = 1'b1;
                            wdata   = {nx, pc, 1'b0};
                            h0_next = h0_reg && (h_reg != '0);
                            st_next = 1'b0;
                            go_next = h_reg + OFS_W'(1);
                            cb_next = {pc, 4'b0};
                        end
                        else if (fr && (OFS_W+2)'(pc) >= (OFS_W+2)'(c_reg.need) + 2
                                 && rest < (OFS_W+2)'(PIECES))
                        begin
                            // new free remainder header
                            we      = 1'b1;
                            waddr   = OFS_W'(rest);
                            wdata   = {nx, OFS_W'(pc - OFS_W'(c_reg.need) - OFS_W'(1)),
                                       1'b1};
                            st_next = 1'b0;
                            go_next = h_reg + OFS_W'(1);
                            cb_next = {OFS_W'(c_reg.need), 4'b0};
                            state_next = S_SPLIT;
                        end
                        else if (nx == '0 || steps_reg == (OFS_W+1)'(PIECES - 1))
                        begin
                            st_next = 1'b1;
                        end
                        else
                        begin
                            h_next     = nx;
                            raddr      = nx;
                            steps_next = steps_reg + 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                endcase
            end
            S_SPLIT:
            begin
                we         = 1'b1;
                wdata      = {OFS_W'(rest), OFS_W'(c_reg.need), 1'b0};
                h0_next    = h0_reg && (h_reg != '0);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                end
                else if (!out_stall)
                begin
                    ov_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            h0_reg    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            h0_reg    <= h0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        h_reg     <= h_next;
        steps_reg <= steps_next;
        st_reg    <= st_next;
        go_reg    <= go_next;
        cb_reg    <= cb_next;
    end

    assign out_valid      = ov_reg;
    assign status         = st_reg;
    assign granted_offset = go_reg;
    assign chunk_bytes    = cb_reg;
    assign busy           = (state_reg != S_IDLE);

endmodule

@@ rtl/first_fit_piece_allocator_top.sv @@
// First-fit allocator over a pool of 16-byte pieces. Each word gives one result word.
// A valid free or query reads one chunk header; an allocate walks chunk headers one at a
// time through the single header memory read port, and a split adds a second header write.
// A two-entry command queue lets new words be accepted while a walk runs.
`include "first_fit_piece_allocator_top_macros.svh"
module first_fit_piece_allocator_top
    import ffpa_pkg::*;
#(
    parameter int PIECES = 16384
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [SIZE_W-1:0]  size_bytes,
    input  logic [OFS_W-1:0]   data_offset,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [OFS_W-1:0]   granted_offset,
    output logic [BYTES_W-1:0] chunk_bytes
);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;
    logic busy;

    ffpa_front #(.PIECES(PIECES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .size_bytes(size_bytes), .data_offset(data_offset),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    ffpa_back #(.PIECES(PIECES)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .granted_offset(granted_offset),
        .chunk_bytes(chunk_bytes), .busy(busy)
    );

    `FFPA_ASSERT_IMP(a_take_idle, cmd_take, !busy && cmd_valid)
    `FFPA_ASSERT_IMP(a_fail_zero, out_valid && status, granted_offset == '0 && chunk_bytes == '0)
    `FFPA_ASSERT_NEXT(a_take_busy, cmd_take, busy)

endmodule
